### src/rmst_pkg.sv
// shared types, widths and codes of the range minimum segment tree
package rmst_pkg;

	// tree size and stored tag width
	localparam int LEAVES   = 1024;
	localparam int TAG_BITS = 16;

	// fixed field widths
	localparam int KEY_W   = 32;
	localparam int OTAG_W  = 16;
	localparam int POS_W   = 10;
	localparam int RANGE_W = 11;
	localparam int CFG_W   = 11;

	// derived widths
	localparam int NODES  = 2 * LEAVES;
	localparam int NODE_W = $clog2(NODES);
	localparam int IDX_W  = NODE_W + 1;
	localparam int CMP_W  = (IDX_W > RANGE_W) ? IDX_W : RANGE_W;

	// leaf count after reset
	localparam logic [CFG_W-1:0] LC_RESET = 11'd1024;

	// request and status codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;
	localparam logic STAT_OK   = 1'b0;
	localparam logic STAT_BAD  = 1'b1;

	typedef logic [KEY_W-1:0]    key_t;
	typedef logic [TAG_BITS-1:0] tag_t;
	typedef logic [NODE_W-1:0]   naddr_t;

	typedef struct packed {
		key_t key;
		tag_t tag;
	} node_t;

	localparam node_t EMPTY_NODE = '{key: '1, tag: '0};

	// one write port and one read port of the node memory
	typedef struct packed {
		logic   we;
		naddr_t waddr;
		node_t  wdata;
		naddr_t raddr;
	} mem_req_t;

	// finished result handed to the output register
	typedef struct packed {
		logic              valid;
		key_t              key;
		logic [OTAG_W-1:0] tag;
		logic              err;
	} res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WLEAF,
		ST_WCLIMB,
		ST_QUERY,
		ST_DONE
	} state_t;

	// input tag to stored width
	function automatic tag_t tag_in(logic [OTAG_W-1:0] t);
		logic [31:0] w;
		w = 32'(t);
		return w[TAG_BITS-1:0];
	endfunction

	// stored tag to output width
	function automatic logic [OTAG_W-1:0] tag_out(tag_t t);
		logic [31:0] w;
		w = 32'(t);
		return w[OTAG_W-1:0];
	endfunction

endpackage

### src/range_min_segment_tree_core.sv
// top level of the range minimum segment tree with config and output registers
//
//  channel  | handshake              | word
//  ---------+------------------------+------------------------------------------
//  config   | cfg_valid / cfg_ready  | leaf_count
//  request  | in_valid / in_stall    | req_type position new_key new_tag
//           |                        | range_begin range_end
//  result   | out_valid / out_stall  | result_key result_tag status
//
// after reset a clearing pass sweeps all 2048 nodes, one per cycle, with in_stall high
// a leaf write does one node write and one sibling read per level
// a query does at most one node read per cycle on the read port
// a rejected request goes straight to the done state; one request is worked on at a time
// a new request is taken while the last result waits in the output register
module range_min_segment_tree_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rmst_pkg::CFG_W-1:0]       leaf_count,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             req_type,
	input  logic [rmst_pkg::POS_W-1:0]       position,
	input  logic [rmst_pkg::KEY_W-1:0]       new_key,
	input  logic [rmst_pkg::OTAG_W-1:0]      new_tag,
	input  logic [rmst_pkg::RANGE_W-1:0]     range_begin,
	input  logic [rmst_pkg::RANGE_W-1:0]     range_end,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [rmst_pkg::KEY_W-1:0]       result_key,
	output logic [rmst_pkg::OTAG_W-1:0]      result_tag,
	output logic                             status
);
	import rmst_pkg::*;

	logic [CFG_W-1:0]  lc_q;
	logic              out_valid_q;
	key_t              res_key_q;
	logic [OTAG_W-1:0] res_tag_q;
	logic              status_q;

	logic     res_ready;
	res_t     res;
	mem_req_t mem_req;
	node_t    rdata;

	assign cfg_ready = 1'b1;
	assign res_ready = !out_valid_q || !out_stall;

	// leaf count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q <= LC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			lc_q <= leaf_count;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register word
	always_ff @(posedge clk) begin
		if (res.valid) begin
			res_key_q <= res.key;
			res_tag_q <= res.tag;
			status_q  <= res.err;
		end
	end

	assign out_valid  = out_valid_q;
	assign result_key = res_key_q;
	assign result_tag = res_tag_q;
	assign status     = status_q;

	rmst_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.position    (position),
		.new_key     (new_key),
		.new_tag     (new_tag),
		.range_begin (range_begin),
		.range_end   (range_end),
		.lc          (lc_q),
		.res_ready   (res_ready),
		.res         (res),
		.mem_req     (mem_req),
		.rdata       (rdata)
	);

	rmst_node_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

endmodule

### src/rmst_node_ram.sv
// node memory: one write port, one registered read port
module rmst_node_ram (
	input  logic               clk,
	input  rmst_pkg::mem_req_t req,
	output rmst_pkg::node_t    rdata
);
	import rmst_pkg::*;

	node_t mem_q [NODES];
	node_t rd_data_q;

	// write and read, read data registered and ready in the next cycle
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rd_data_q <= mem_q[req.raddr];
	end

	assign rdata = rd_data_q;

endmodule

### src/rmst_ctrl.sv
// sequencer for clear pass, leaf write with climb, and range query walk
module rmst_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             req_type,
	input  logic [rmst_pkg::POS_W-1:0]       position,
	input  logic [rmst_pkg::KEY_W-1:0]       new_key,
	input  logic [rmst_pkg::OTAG_W-1:0]      new_tag,
	input  logic [rmst_pkg::RANGE_W-1:0]     range_begin,
	input  logic [rmst_pkg::RANGE_W-1:0]     range_end,
	input  logic [rmst_pkg::CFG_W-1:0]       lc,
	input  logic                             res_ready,
	output rmst_pkg::res_t                   res,
	output rmst_pkg::mem_req_t               mem_req,
	input  rmst_pkg::node_t                  rdata
);
	import rmst_pkg::*;

	state_t state_q, state_d;
	naddr_t clr_q;
	logic   side_q;
	logic   fold_s1;

	node_t            acc_q;
	node_t            cur_q;
	logic             err_q;
	naddr_t           k_q;
	logic [IDX_W-1:0] b_q, e_q;

	logic             acc_in;
	logic [CMP_W-1:0] lc_w, n_eff, pos_w, b_w, e_w;
	logic             wr_bad, q_bad, req_bad;
	naddr_t           par;
	node_t            pick;
	logic             q_exit, q_rd, q_side_n;
	naddr_t           q_raddr;
	logic [IDX_W-1:0] q_b_n, q_e_n, e_dec;

	assign acc_in = in_valid && !in_stall;

	// effective leaf count and request checks
	always_comb begin
		lc_w  = CMP_W'(lc);
		if (lc_w == '0) begin
			n_eff = CMP_W'(1);
		end else if (lc_w > CMP_W'(LEAVES)) begin
			n_eff = CMP_W'(LEAVES);
		end else begin
			n_eff = lc_w;
		end
		pos_w   = CMP_W'(position);
		b_w     = CMP_W'(range_begin);
		e_w     = CMP_W'(range_end);
		wr_bad  = pos_w >= n_eff;
		q_bad   = (e_w > n_eff) || (b_w > e_w);
		req_bad = (req_type == REQ_WRITE) ? wr_bad : q_bad;
	end

	// climb step: parent takes the smaller child, climbed child on a tie
	always_comb begin
		par  = {1'b0, k_q[NODE_W-1:1]};
		pick = (rdata.key < cur_q.key) ? rdata : cur_q;
	end

	// query step: left boundary then right boundary, one read a cycle
	always_comb begin
		e_dec    = e_q - IDX_W'(1);
		q_exit   = 1'b0;
		q_rd     = 1'b0;
		q_raddr  = b_q[NODE_W-1:0];
		q_b_n    = b_q;
		q_e_n    = e_q;
		q_side_n = 1'b0;
		if (!side_q) begin
			if (!(b_q < e_q)) begin
				q_exit = 1'b1;
			end else if (b_q[0]) begin
				q_rd     = 1'b1;
				q_raddr  = b_q[NODE_W-1:0];
				q_b_n    = b_q + IDX_W'(1);
				q_side_n = 1'b1;
			end else if (e_q[0]) begin
				q_rd    = 1'b1;
				q_raddr = e_dec[NODE_W-1:0];
				q_b_n   = b_q >> 1;
				q_e_n   = e_dec >> 1;
			end else begin
				q_b_n = b_q >> 1;
				q_e_n = e_q >> 1;
			end
		end else begin
			q_b_n = b_q >> 1;
			if (e_q[0]) begin
				q_rd    = 1'b1;
				q_raddr = e_dec[NODE_W-1:0];
				q_e_n   = e_dec >> 1;
			end else begin
				q_e_n = e_q >> 1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == {NODE_W{1'b1}}) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (acc_in) begin
					if (req_bad) state_d = ST_DONE;
					else if (req_type == REQ_WRITE) state_d = ST_WLEAF;
					else state_d = ST_QUERY;
				end
			end
			ST_WLEAF: begin
				state_d = (k_q == NODE_W'(1)) ? ST_DONE : ST_WCLIMB;
			end
			ST_WCLIMB: begin
				if (par == NODE_W'(1)) state_d = ST_DONE;
			end
			ST_QUERY: begin
				if (q_exit) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// outputs: handshake, memory port, result
	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		mem_req.we    = 1'b0;
		mem_req.waddr = k_q;
		mem_req.wdata = cur_q;
		mem_req.raddr = q_raddr;
		res.valid     = 1'b0;
		res.key       = acc_q.key;
		res.tag       = tag_out(acc_q.tag);
		res.err       = err_q;
		case (state_q)
			ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = clr_q;
				mem_req.wdata = EMPTY_NODE;
			end
			ST_WLEAF: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = k_q;
				mem_req.wdata = cur_q;
				mem_req.raddr = {k_q[NODE_W-1:1], ~k_q[0]};
			end
			ST_WCLIMB: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = par;
				mem_req.wdata = pick;
				mem_req.raddr = {par[NODE_W-1:1], ~par[0]};
			end
			ST_DONE: begin
				res.valid = res_ready;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			side_q  <= 1'b0;
			fold_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + NODE_W'(1);
			if (state_q == ST_QUERY) side_q <= q_side_n;
			else side_q <= 1'b0;
			fold_s1 <= (state_q == ST_QUERY) && q_rd;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc_in) begin
					err_q <= req_bad ? STAT_BAD : STAT_OK;
					cur_q <= '{key: new_key, tag: tag_in(new_tag)};
					if (!req_bad && req_type == REQ_WRITE) begin
						acc_q <= '{key: new_key, tag: tag_in(new_tag)};
					end else begin
						acc_q <= EMPTY_NODE;
					end
					k_q <= NODE_W'(pos_w + n_eff);
					b_q <= IDX_W'(b_w + n_eff);
					e_q <= IDX_W'(e_w + n_eff);
				end
			end
			ST_WCLIMB: begin
				cur_q <= pick;
				k_q   <= par;
			end
			ST_QUERY: begin
				b_q <= q_b_n;
				e_q <= q_e_n;
				// fold the node read last cycle, accumulator wins ties
				if (fold_s1 && (rdata.key < acc_q.key)) acc_q <= rdata;
			end
			default: begin
			end
		endcase
	end

endmodule
